@@ rtl/tcw_pkg.sv @@
// Shared types and constants for the text console character writer.
// Holds command and operation codes, the queue entry type and the sequencer states.
// No dependencies.
package tcw_pkg;

	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_STOP_DEF = 8;

	localparam int QUEUE_DEPTH = 2;

	localparam int IN_W  = 24;
	localparam int OUT_W = 40;

	localparam logic [7:0] SPACE_CODE = 8'h20;
	localparam logic [7:0] BS_CODE    = 8'h08;
	localparam logic [7:0] TAB_CODE   = 8'h09;
	localparam logic [7:0] LF_CODE    = 8'h0A;
	localparam logic [7:0] CR_CODE    = 8'h0D;

	localparam logic [7:0]  ATTR_RESET  = 8'h07;
	localparam logic [15:0] BLANK_RESET = 16'h0720;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		K_PRINT,
		K_BS,
		K_TAB,
		K_CR,
		K_LF,
		K_SKIP,
		K_CLEAR,
		K_READ
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  char_code;
		logic [10:0] cell_addr;
	} op_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_ADDR,
		ST_EXEC,
		ST_READ,
		ST_READ_DATA,
		ST_SCROLL_COPY,
		ST_SCROLL_DRAIN,
		ST_SCROLL_BLANK,
		ST_CLEAR,
		ST_DONE
	} state_t;

endpackage

@@ rtl/tcw_front.sv @@
// Input stage: accepts items, decodes command and control bytes into an operation.
// Depends on tcw_pkg.
module tcw_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     enable,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [tcw_pkg::IN_W-1:0] s_axis_tdata,
	output tcw_pkg::op_t             op,
	output logic                     op_valid,
	input  logic                     op_ready
);
	import tcw_pkg::*;

	logic [1:0]  cmd;
	logic [7:0]  ch;
	logic [10:0] addr;
	op_t         op_c;
	op_t         op_s1;
	logic        valid_s1;

	assign cmd  = s_axis_tdata[1:0];
	assign ch   = s_axis_tdata[9:2];
	assign addr = s_axis_tdata[20:10];

	always_comb begin
		op_c.char_code = ch;
		op_c.cell_addr = addr;
		op_c.kind      = K_SKIP;
		case (cmd_t'(cmd))
			CMD_PUT: begin
				if (ch == BS_CODE) begin
					op_c.kind = K_BS;
				end else if (ch == TAB_CODE) begin
					op_c.kind = K_TAB;
				end else if (ch == CR_CODE) begin
					op_c.kind = K_CR;
				end else if (ch == LF_CODE) begin
					op_c.kind = K_LF;
				end else if (ch >= SPACE_CODE) begin
					op_c.kind = K_PRINT;
				end else begin
					op_c.kind = K_SKIP;
				end
			end
			CMD_CLEAR: op_c.kind = K_CLEAR;
			CMD_READ:  op_c.kind = K_READ;
			default:   op_c.kind = K_SKIP;
		endcase
	end

	assign s_axis_tready = enable && (!valid_s1 || op_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end else if (op_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1 <= op_c;
		end
	end

	assign op       = op_s1;
	assign op_valid = valid_s1;

endmodule

@@ rtl/tcw_queue.sv @@
// Short operation queue between the decode stage and the cell sequencer.
// Depends on tcw_pkg for the entry type.
module tcw_queue #(
	parameter int DEPTH = tcw_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  tcw_pkg::op_t in_data,
	input  logic         in_valid,
	output logic         in_ready,
	output tcw_pkg::op_t out_data,
	output logic         out_valid,
	input  logic         out_ready
);
	import tcw_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	op_t           entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          push;
	logic          pop;

	assign in_ready  = (count_q != NW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

@@ rtl/tcw_back.sv @@
// Cell sequencer: owns the cell store, the cursor and the attribute register,
// runs puts, scrolls, clears and reads, and holds the result register. Depends on tcw_pkg.
module tcw_back #(
	parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS     = tcw_pkg::ROWS_DEF,
	parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [7:0]                cfg_data,
	input  tcw_pkg::op_t              op,
	input  logic                      op_valid,
	output logic                      op_ready,
	output logic                      init_done,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [tcw_pkg::OUT_W-1:0] m_axis_tdata
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int NW    = $clog2(COLUMNS + TAB_STOP);
	localparam int RW    = $clog2(ROWS);

	state_t           state_q;
	state_t           state_d;
	logic [AW-1:0]    p_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [7:0]       attr_q;
	op_t              op_q;
	logic [AW-1:0]    addr_q;
	logic             scrolled_q;
	logic [15:0]      value_q;
	logic [15:0]      rd_data_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic [15:0]      mem [CELLS];
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [15:0]      mem_wd;
	logic             mem_re;
	logic [AW-1:0]    mem_ra;

	logic [NW-1:0]    tab_tbl [COLUMNS];
	logic [NW-1:0]    col_adv;
	logic             lf_inc;
	logic             wrap;
	logic             need_scroll;
	logic [CW-1:0]    col_next;
	logic [RW-1:0]    row_next;
	logic             read_ok;
	logic             out_load;
	logic [15:0]      blank;
	logic [AW-1:0]    lin;

	for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
		assign tab_tbl[g] = NW'(g + TAB_STOP - (g % TAB_STOP));
	end

	assign blank     = {attr_q, SPACE_CODE};
	assign read_ok   = (32'(op_q.cell_addr) < 32'(CELLS));
	assign cfg_ready = 1'b1;
	assign init_done = (state_q != ST_INIT);
	assign lin       = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);

	// cursor after a put, before any scroll
	always_comb begin
		col_adv = NW'(col_q);
		lf_inc  = 1'b0;
		case (op_q.kind)
			K_PRINT: col_adv = NW'(col_q) + NW'(1);
			K_BS: begin
				if (col_q != '0) begin
					col_adv = NW'(col_q) - NW'(1);
				end
			end
			K_TAB: col_adv = tab_tbl[col_q];
			K_CR:  col_adv = '0;
			K_LF: begin
				col_adv = '0;
				lf_inc  = 1'b1;
			end
			default: col_adv = NW'(col_q);
		endcase
		wrap        = (col_adv >= NW'(COLUMNS));
		col_next    = wrap ? '0 : CW'(col_adv);
		need_scroll = (lf_inc || wrap) && (row_q == RW'(ROWS - 1));
		row_next    = (need_scroll || !(lf_inc || wrap)) ? row_q : row_q + RW'(1);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (p_q == AW'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (op_valid) begin
					case (op.kind)
						K_CLEAR: state_d = ST_CLEAR;
						K_READ:  state_d = ST_READ;
						default: state_d = ST_ADDR;
					endcase
				end
			end
			ST_ADDR:      state_d = ST_EXEC;
			ST_EXEC:      state_d = need_scroll ? ST_SCROLL_COPY : ST_DONE;
			ST_READ:      state_d = ST_READ_DATA;
			ST_READ_DATA: state_d = ST_DONE;
			ST_SCROLL_COPY: begin
				if (p_q == AW'(CELLS - COLUMNS - 1)) begin
					state_d = ST_SCROLL_DRAIN;
				end
			end
			ST_SCROLL_DRAIN: state_d = ST_SCROLL_BLANK;
			ST_SCROLL_BLANK: begin
				if (p_q == AW'(CELLS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_CLEAR: begin
				if (p_q == AW'(CELLS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = p_q;
		mem_wd   = blank;
		mem_re   = 1'b0;
		mem_ra   = AW'(op_q.cell_addr);
		op_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				mem_wd = BLANK_RESET;
			end
			ST_IDLE: op_ready = 1'b1;
			ST_EXEC: begin
				mem_we = (op_q.kind == K_PRINT);
				mem_wa = addr_q;
				mem_wd = {attr_q, op_q.char_code};
			end
			ST_READ: mem_re = read_ok;
			ST_SCROLL_COPY: begin
				// read one row ahead, write back the cell read last cycle
				mem_re = 1'b1;
				mem_ra = p_q + AW'(COLUMNS);
				mem_we = (p_q != '0);
				mem_wa = p_q - AW'(1);
				mem_wd = rd_data_q;
			end
			ST_SCROLL_DRAIN: begin
				mem_we = 1'b1;
				mem_wa = p_q - AW'(1);
				mem_wd = rd_data_q;
			end
			ST_SCROLL_BLANK: mem_we = 1'b1;
			ST_CLEAR:        mem_we = 1'b1;
			ST_DONE:         out_load = !out_valid_q || m_axis_tready;
			default:         op_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			p_q         <= '0;
			col_q       <= '0;
			row_q       <= '0;
			attr_q      <= ATTR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				attr_q <= cfg_data;
			end
			case (state_q)
				ST_INIT:         p_q <= p_q + AW'(1);
				ST_IDLE:         p_q <= '0;
				ST_SCROLL_COPY:  p_q <= p_q + AW'(1);
				ST_SCROLL_BLANK: p_q <= p_q + AW'(1);
				ST_CLEAR: begin
					p_q   <= p_q + AW'(1);
					col_q <= '0;
					row_q <= '0;
				end
				ST_EXEC: begin
					col_q <= col_next;
					row_q <= row_next;
				end
				default: p_q <= p_q;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && op_valid) begin
			op_q       <= op;
			scrolled_q <= 1'b0;
			value_q    <= '0;
		end
		if (state_q == ST_ADDR) begin
			addr_q <= lin;
		end
		if (state_q == ST_EXEC) begin
			scrolled_q <= need_scroll;
		end
		if (state_q == ST_READ_DATA && read_ok) begin
			value_q <= rd_data_q;
		end
		if (out_load) begin
			out_data_q <= {value_q, scrolled_q, 11'(lin), 5'(row_q), 7'(col_q)};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/text_console_char_writer.sv @@
// Channel    Direction  Handshake                     Payload
// s_axis     in         s_axis_tvalid/s_axis_tready   cmd, char_code, cell_addr
// m_axis     out        m_axis_tvalid/m_axis_tready   cursor_col, cursor_row, cursor_linear,
//                                                     scrolled, cell_value
// cfg        in         cfg_valid/cfg_ready           attribute
//
// Put items pass the sequencer states ADDR, EXEC and DONE, read items READ, READ_DATA
// and DONE. A put that scrolls copies each row up and blanks the bottom row, and a clear
// blanks every cell, both through the single write port of the cell store. After reset
// a clearing pass fills the store with blanks while s_axis_tready stays low; cfg is
// always ready. The decode stage and a two-entry queue keep taking items, until both
// are full, while the sequencer works or a result waits on m_axis_tready.
module text_console_char_writer #(
	parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS     = tcw_pkg::ROWS_DEF,
	parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// [1:0] cmd, [9:2] char_code, [20:10] cell_addr, [23:21] zero
	input  logic [tcw_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// [6:0] cursor_col, [11:7] cursor_row, [22:12] cursor_linear, [23] scrolled,
	// [39:24] cell_value
	output logic [tcw_pkg::OUT_W-1:0] m_axis_tdata,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [7:0]                cfg_data
);
	import tcw_pkg::*;

	op_t  fe_op;
	logic fe_valid;
	logic fe_ready;
	op_t  q_op;
	logic q_valid;
	logic q_ready;
	logic init_done;

	tcw_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.enable        (init_done),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.op            (fe_op),
		.op_valid      (fe_valid),
		.op_ready      (fe_ready)
	);

	tcw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (fe_op),
		.in_valid  (fe_valid),
		.in_ready  (fe_ready),
		.out_data  (q_op),
		.out_valid (q_valid),
		.out_ready (q_ready)
	);

	tcw_back #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.op            (q_op),
		.op_valid      (q_valid),
		.op_ready      (q_ready),
		.init_done     (init_done),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

@@ rtl/tcw_checker.sv @@
// Port-level checks for text_console_char_writer, attached by bind.
// Depends on tcw_pkg and the top level's port names.
module tcw_checker #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [tcw_pkg::OUT_W-1:0] m_axis_tdata
);
	import tcw_pkg::*;

	localparam bit EXACT = (COLUMNS <= 128) && (ROWS <= 32);

	logic [6:0]  f_col;
	logic [4:0]  f_row;
	logic [10:0] f_lin;
	logic        f_scr;
	logic [15:0] f_val;

	assign f_col = m_axis_tdata[6:0];
	assign f_row = m_axis_tdata[11:7];
	assign f_lin = m_axis_tdata[22:12];
	assign f_scr = m_axis_tdata[23];
	assign f_val = m_axis_tdata[39:24];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_linear: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && EXACT |-> f_lin == 11'(32'(f_row) * COLUMNS + 32'(f_col)))
		else $error("cursor_linear disagrees with cursor row and column");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && f_scr |-> f_row == 5'(ROWS - 1))
		else $error("scroll left cursor off the bottom row");

	a_scroll_val: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && f_scr |-> f_val == '0)
		else $error("scrolling result carries a cell value");

endmodule

bind text_console_char_writer tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
